### design/smiou_pkg.sv
// ----------------------------------------------------------------------------
// smiou_pkg
// Shared widths, constants and types of the soft mask IoU block.
// ----------------------------------------------------------------------------
package smiou_pkg;

  localparam int PIX_W          = 9;
  localparam int ACC_W          = 33;
  localparam int IOU_W          = 17;
  localparam int IOU_FRAC       = 16;
  localparam int QUOT_BITS      = 17;
  localparam int NUM_W          = ACC_W + IOU_FRAC + 1;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DEF_MAX_PIXELS = 65536;
  localparam int DEF_FRAC_BITS  = 8;

  localparam logic [IOU_W-1:0] IOU_ONE = IOU_W'(65536);

  // sums of one finished mask pair
  typedef struct packed {
    logic [ACC_W-1:0] isum;
    logic [ACC_W-1:0] usum;
    logic             sat;
  } pair_t;

endpackage

### design/smiou_if.sv
// ----------------------------------------------------------------------------
// smiou_if
// Valid/ready channels for pixel pairs and IoU results.
// ----------------------------------------------------------------------------
interface smiou_in_if import smiou_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pred_value;
  logic [PIX_W-1:0] truth_value;
  logic             last_pixel;

  modport source (output valid, pred_value, truth_value, last_pixel, input ready);
  modport sink   (input valid, pred_value, truth_value, last_pixel, output ready);
endinterface

interface smiou_out_if import smiou_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IOU_W-1:0] iou;
  logic             empty_union;
  logic             overflow;

  modport source (output valid, iou, empty_union, overflow, input ready);
  modport sink   (input valid, iou, empty_union, overflow, output ready);
endinterface

### design/smiou_front.sv
// ----------------------------------------------------------------------------
// smiou_front
// Clamps each pixel pair, forms the intersection and union terms and keeps
// the saturating sums; a last pixel hands the pair's sums to the queue.
// ----------------------------------------------------------------------------
module smiou_front import smiou_pkg::*; #(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  smiou_in_if.sink   in_pix,
  input  logic       q_full,
  output logic       push,
  output pair_t      push_data
);

  localparam int CLAMP_W = (FRAC_BITS + 1 > PIX_W) ? FRAC_BITS + 1 : PIX_W;
  localparam int TERM_W  = (FRAC_BITS + 10 > 18) ? FRAC_BITS + 10 : 18;
  localparam int CNT_W   = $clog2(MAX_PIXELS + 2);
  localparam logic [CLAMP_W-1:0] PIX_ONE = CLAMP_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]   CNT_MAX = CNT_W'(MAX_PIXELS);

  logic [ACC_W-1:0] isum_r, usum_r;
  logic             sat_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [PIX_W-1:0]  a_c, b_c;
  logic [17:0]       prod;
  logic [TERM_W-1:0] uni;
  logic [ACC_W:0]    isum_wide, usum_wide;
  logic [ACC_W-1:0]  isum_nxt, usum_nxt;
  logic              sat_nxt;
  logic              accept;

  assign in_pix.ready = !q_full;
  assign accept       = in_pix.valid && in_pix.ready;

  // values above full scale count as full scale
  assign a_c = (CLAMP_W'(in_pix.pred_value) > PIX_ONE)  ? PIX_ONE[PIX_W-1:0] : in_pix.pred_value;
  assign b_c = (CLAMP_W'(in_pix.truth_value) > PIX_ONE) ? PIX_ONE[PIX_W-1:0] : in_pix.truth_value;

  assign prod = a_c * b_c;
  assign uni  = (TERM_W'({1'b0, a_c} + {1'b0, b_c}) << FRAC_BITS) - TERM_W'(prod);

  assign isum_wide = {1'b0, isum_r} + (ACC_W+1)'(prod);
  assign usum_wide = {1'b0, usum_r} + (ACC_W+1)'(uni);
  assign isum_nxt  = isum_wide[ACC_W] ? '1 : isum_wide[ACC_W-1:0];
  assign usum_nxt  = usum_wide[ACC_W] ? '1 : usum_wide[ACC_W-1:0];

  assign cnt_nxt = (cnt_r <= CNT_MAX) ? cnt_r + CNT_W'(1) : cnt_r;
  assign sat_nxt = sat_r || isum_wide[ACC_W] || usum_wide[ACC_W] || (cnt_nxt > CNT_MAX);

  assign push           = accept && in_pix.last_pixel;
  assign push_data.isum = isum_nxt;
  assign push_data.usum = usum_nxt;
  assign push_data.sat  = sat_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      isum_r <= '0;
      usum_r <= '0;
      sat_r  <= 1'b0;
      cnt_r  <= '0;
    end else if (accept) begin
      if (in_pix.last_pixel) begin
        isum_r <= '0;
        usum_r <= '0;
        sat_r  <= 1'b0;
        cnt_r  <= '0;
      end else begin
        isum_r <= isum_nxt;
        usum_r <= usum_nxt;
        sat_r  <= sat_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  // per pixel a*b never exceeds the union term
  a_isum_le_usum: assert property (@(posedge clk) disable iff (!rst_n)
    isum_r <= usum_r) else $error("intersection sum above union sum");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full) else $error("push into full queue");

endmodule

### design/smiou_queue.sv
// ----------------------------------------------------------------------------
// smiou_queue
// Short queue of finished pair sums between the accumulator and the divider.
// ----------------------------------------------------------------------------
module smiou_queue import smiou_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  pair_t push_data,
  input  logic  pop,
  output pair_t head,
  output logic  q_valid,
  output logic  q_full
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

  pair_t            entry_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;

  assign head    = entry_r[rd_ptr_r];
  assign q_valid = (cnt_r != '0);
  assign q_full  = (cnt_r == CNT_W'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

### design/smiou_div.sv
// ----------------------------------------------------------------------------
// smiou_div
// Restoring divider, one quotient bit per cycle, forming the rounded ratio
// of the two sums and holding it in the result register.
// ----------------------------------------------------------------------------
module smiou_div import smiou_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  pair_t      head,
  input  logic       q_valid,
  output logic       pop,
  smiou_out_if.source out_res
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam int STEP_W = $clog2(QUOT_BITS);

  logic [1:0]           state_r;
  logic [ACC_W-1:0]     usum_r, rem_r;
  logic [QUOT_BITS-1:0] nlo_r, q_r;
  logic [STEP_W-1:0]    step_r;
  logic                 empty_r, sat_r;
  logic                 out_valid_r, out_empty_r, out_ovf_r;
  logic [IOU_W-1:0]     out_iou_r;

  logic [NUM_W-1:0]     num;
  logic [ACC_W:0]       trial, diff;
  logic                 qbit;

  assign pop   = (state_r == S_IDLE) && q_valid;
  // numerator with half the divisor added for round to nearest
  assign num   = {1'b0, head.isum, IOU_FRAC'(0)} + NUM_W'(head.usum >> 1);
  assign trial = {rem_r, nlo_r[QUOT_BITS-1]};
  assign diff  = trial - {1'b0, usum_r};
  assign qbit  = (trial >= {1'b0, usum_r});

  assign out_res.valid       = out_valid_r;
  assign out_res.iou         = out_iou_r;
  assign out_res.empty_union = out_empty_r;
  assign out_res.overflow    = out_ovf_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_res.ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            usum_r <= head.usum;
            sat_r  <= head.sat;
            q_r    <= '0;
            if (head.usum == '0) begin
              empty_r <= 1'b1;
              state_r <= S_DONE;
            end else begin
              empty_r <= 1'b0;
              rem_r   <= num[NUM_W-1:QUOT_BITS];
              nlo_r   <= num[QUOT_BITS-1:0];
              step_r  <= STEP_W'(QUOT_BITS - 1);
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_r <= qbit ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
          q_r   <= {q_r[QUOT_BITS-2:0], qbit};
          nlo_r <= nlo_r << 1;
          if (step_r == '0) begin
            state_r <= S_DONE;
          end else begin
            step_r <= step_r - STEP_W'(1);
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_res.ready) begin
            out_valid_r <= 1'b1;
            out_iou_r   <= (q_r > IOU_ONE) ? IOU_ONE : q_r;
            out_empty_r <= empty_r;
            out_ovf_r   <= sat_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) |-> (rem_r < usum_r))
    else $error("partial remainder not below divisor");

  a_iou_capped: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_iou_r <= IOU_ONE)) else $error("iou above one");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> (out_iou_r == '0))
    else $error("empty union with nonzero iou");

endmodule

### design/soft_mask_iou.sv
// ----------------------------------------------------------------------------
// soft_mask_iou
// Soft intersection over union of one pair of fuzzy masks, streamed as
// pixel pairs.
// ----------------------------------------------------------------------------
// Pixels are taken at one per cycle: the accumulator adds the intersection
// term a*b and the union term a+b-a*b of every pixel into saturating 33-bit
// sums. The pixel marked last pushes the pair's sums into a two-entry queue
// and the sums restart at zero. A restoring divider takes one queued pair at
// a time: a load step, 17 quotient-bit steps and a hand-off step into the
// result register, with the quotient steps skipped when the union sum is
// zero. While results are taken, a pair of at least 19 pixels never slows
// the pixel stream; shorter pairs back up into the queue and the
// input stalls while it is full, as it does while a result waits to be
// taken. A result transaction carries iou (65536 means 1.0, rounded to
// nearest), empty_union when the union sum was zero (iou then 0), and
// overflow when a sum saturated or the pair ran past MAX_PIXELS pixels.
module soft_mask_iou import smiou_pkg::*; #(
  parameter int MAX_PIXELS = DEF_MAX_PIXELS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  smiou_in_if.sink    in_pix,
  smiou_out_if.source out_res
);

  logic  push, pop, q_full, q_valid;
  pair_t push_data, head;

  smiou_front #(
    .MAX_PIXELS (MAX_PIXELS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_pix    (in_pix),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  smiou_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_valid   (q_valid),
    .q_full    (q_full)
  );

  smiou_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_valid (q_valid),
    .pop     (pop),
    .out_res (out_res)
  );

endmodule
